>>> hdl/assert_macros.svh
// Assertion macros shared by the binary search engine RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bse_pkg.sv
// Package for the binary search engine: opcodes, defaults and the
// command/status structs between controller and datapath. No dependencies.
package bse_pkg;

    localparam int DEF_TABLE_DEPTH   = 256;
    localparam int DEF_ELEMENT_WIDTH = 32;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    typedef struct packed {
        logic clear;
        logic append;
        logic start;
        logic rd;
        logic step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic hit;
        logic full;
    } sts_t;

endpackage

>>> hdl/bse_ctrl.sv
// Binary search engine controller: handshakes and probe sequencing.
// Depends on bse_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bse_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    output logic              out_valid,
    input  logic              out_stall,
    output bse_pkg::cmd_t     cmd,
    input  bse_pkg::sts_t     sts
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = (state_reg != S_IDLE);
        accept     = in_valid && !in_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        bse_pkg::OP_CLEAR:  cmd.clear  = 1'b1;
                        bse_pkg::OP_APPEND: cmd.append = 1'b1;
                        bse_pkg::OP_SEARCH:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_PROBE;
                        end
                        default: ;
                    endcase
                end
            end
            S_PROBE:
            begin
                if (sts.empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.step   = 1'b1;
                state_next = sts.hit ? S_DONE : S_PROBE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        out_valid_next = cmd.emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `BSE_ASSERT_IMP(a_cmp_after_probe, state_reg == S_CMP, $past(state_reg) == S_PROBE,
        "compare state not entered from a probe")
    `BSE_ASSERT_IMP(a_emit_no_overwrite, cmd.emit, !(out_valid_reg && out_stall),
        "result overwritten while stalled")
    `BSE_ASSERT_NXT(a_emit_valid, cmd.emit, out_valid_reg,
        "emitted result not presented")

endmodule

>>> hdl/bse_dpath.sv
// Binary search engine datapath: element memory, count, search bounds,
// compare and result registers. Depends on bse_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bse_dpath
#(
    parameter int TABLE_DEPTH   = bse_pkg::DEF_TABLE_DEPTH,
    parameter int ELEMENT_WIDTH = bse_pkg::DEF_ELEMENT_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [31:0]  operand_value,
    input  bse_pkg::cmd_t       cmd,
    output bse_pkg::sts_t       sts,
    output logic                found,
    output logic [7:0]          match_index
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int XW = (ELEMENT_WIDTH > 32) ? ELEMENT_WIDTH : 32;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [ELEMENT_WIDTH-1:0] mem [TABLE_DEPTH];

    logic signed [XW-1:0]     ext;
    logic [ELEMENT_WIDTH-1:0] elem;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            lo_reg, hx_reg, mid_reg, idx_reg;
    logic [CW-1:0]            span, mid;
    logic [ELEMENT_WIDTH-1:0] key_reg, rdata_reg;
    logic                     hit_reg;
    logic                     eq, lt;
    logic                     found_reg;
    logic [7:0]               index_reg;

    assign ext  = XW'(operand_value);
    assign elem = ext[ELEMENT_WIDTH-1:0];

    assign span = hx_reg - lo_reg - 1'b1;
    assign mid  = lo_reg + (span >> 1);
    assign eq   = (rdata_reg == key_reg);
    assign lt   = ($signed(rdata_reg) < $signed(key_reg));

    assign sts.empty = (lo_reg >= hx_reg);
    assign sts.hit   = eq;
    assign sts.full  = (count_reg == DEPTH_C);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.append && !sts.full)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append && !sts.full)
        begin
            mem[count_reg[AW-1:0]] <= elem;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[mid[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            lo_reg  <= '0;
            hx_reg  <= count_reg;
            key_reg <= elem;
            hit_reg <= 1'b0;
        end
        if (cmd.rd)
        begin
            mid_reg <= mid;
        end
        if (cmd.step)
        begin
            if (eq)
            begin
                hit_reg <= 1'b1;
                idx_reg <= mid_reg;
            end
            else if (lt)
            begin
                lo_reg <= mid_reg + 1'b1;
            end
            else
            begin
                hx_reg <= mid_reg;
            end
        end
        if (cmd.emit)
        begin
            found_reg <= hit_reg;
            index_reg <= hit_reg ? 8'(idx_reg) : 8'd0;
        end
    end

    assign found       = found_reg;
    assign match_index = index_reg;

    `BSE_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= DEPTH_C,
        "element count beyond table depth")
    `BSE_ASSERT_IMP(a_probe_in_range, cmd.rd, mid < count_reg,
        "probe outside loaded entries")

endmodule

>>> hdl/binary_search_engine.sv
// Binary search engine: a table of signed words filled in ascending order
// and searched by iterative binary search.
// Input channel (in_valid/in_stall): opcode and operand_value. Opcode clear
// empties the table, append stores the word at the next free entry (ignored
// when full), search looks up the key. An unused opcode is taken and dropped.
// Clear and append give no result.
// Output channel (out_valid/out_stall): found and match_index, one transfer
// per search; match_index is 0 when found is 0.
// A search probes until a compare matches or the search bounds are empty: each
// probe is one registered read of the element memory and one compare in the
// next cycle; the result shows in the same cycle in which the next item can be
// taken. With N loaded entries there are at most floor(log2 N) + 1 probes.
// The result sits in an output register; the next item is taken while it
// waits. A stalled receiver holds the result and blocks only a search that
// finishes before the previous result is taken.
// Reset empties the table; memory contents are not cleared.
// Depends on bse_pkg, bse_ctrl, bse_dpath.

module binary_search_engine
#(
    parameter int TABLE_DEPTH   = bse_pkg::DEF_TABLE_DEPTH,
    parameter int ELEMENT_WIDTH = bse_pkg::DEF_ELEMENT_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] operand_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               found,
    output logic [7:0]         match_index
);

    bse_pkg::cmd_t cmd;
    bse_pkg::sts_t sts;

    bse_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    bse_dpath
    #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    )
    u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_value (operand_value),
        .cmd           (cmd),
        .sts           (sts),
        .found         (found),
        .match_index   (match_index)
    );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for binary_search_engine: loads sorted and unsorted tables,
// runs searches under random idling and a long output hold-off, checks every result.
// Depends on bse_pkg and the binary_search_engine RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int         TABLE_DEPTH  = bse_pkg::DEF_TABLE_DEPTH;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         DRAIN_CYCLES = 50;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         MAX_REPORTS  = 10;
    localparam longint     WORD_MIN     = -64'sd2147483648;
    localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] W_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic       hit;
        logic [7:0] idx;
    } search_answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         opcode = bse_pkg::OP_CLEAR;
    logic signed [31:0] operand_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               found;
    logic [7:0]         match_index;

    logic signed [31:0] stored_words [TABLE_DEPTH];
    int                 loaded_count = 0;
    search_answer_t     answers_due [$];
    logic signed [31:0] loaded [$];

    int  errors = 0;
    int  n_in = 0;
    int  n_results = 0;
    int  n_hits = 0;
    int  n_dropped = 0;
    int  cycle_count = 0;
    bit  send_gaps = 1'b1;
    int  stall_pct = 25;
    int  holds_asked = 0;
    int  holds_served = 0;
    int  stall_left = 0;

    binary_search_engine DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .match_index   (match_index)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers still due", cycle_count,
                     answers_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic search_answer_t binary_lookup(logic signed [31:0] key);
        int             lo;
        int             hi;
        int             mid;
        search_answer_t ans;
        ans = '0;
        lo  = 0;
        hi  = loaded_count - 1;
        while (lo <= hi && !ans.hit)
        begin
            mid = lo + (hi - lo) / 2;
            if (stored_words[mid] == key)
            begin
                ans.hit = 1'b1;
                ans.idx = mid[7:0];
            end
            else if (stored_words[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return ans;
    endfunction

    function automatic void apply_table_op(logic [1:0] op, logic signed [31:0] val);
        case (op)
            bse_pkg::OP_CLEAR:
                loaded_count = 0;
            bse_pkg::OP_APPEND:
                if (loaded_count < TABLE_DEPTH)
                begin
                    stored_words[loaded_count] = val;
                    loaded_count++;
                end
                else
                    n_dropped++;
            bse_pkg::OP_SEARCH:
                answers_due.push_back(binary_lookup(val));
            default:
                ;
        endcase
    endfunction

    function automatic void note_failure(string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // input transfers feed the table predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            n_in++;
            apply_table_op(opcode, operand_value);
        end
    end

    always @(posedge clk)
    begin : result_check
        search_answer_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (found === 1'b1)
                n_hits++;
            if (answers_due.size() == 0)
                note_failure($sformatf("unexpected result found=%0b index=%0d",
                                       found, match_index));
            else
            begin
                due = answers_due.pop_front();
                if (found !== due.hit || match_index !== due.idx)
                    note_failure($sformatf(
                        "result %0d: expected found=%0b index=%0d, got found=%0b index=%0d",
                        n_results, due.hit, due.idx, found, match_index));
            end
        end
    end

    function automatic int pick_stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 93)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            stall_left   <= 0;
            holds_served <= 0;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served <= holds_asked;
            stall_left   <= HOLD_CYCLES - 1;
            out_stall    <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left <= pick_stall_len() - 1;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] rand_word();
        return $urandom;
    endfunction

    function automatic logic signed [31:0] pick_key();
        int                 r;
        logic signed [31:0] v;
        r = $urandom_range(0, 9);
        if (loaded.size() == 0 || r < 2)
            return rand_word();
        v = loaded[$urandom_range(0, loaded.size() - 1)];
        if (r < 7)
            return v;
        else if (r == 7)
            return v + 1;
        return v - 1;
    endfunction

    // called just after a rising edge; returns at the edge of the transfer
    task automatic send_item(input logic [1:0] op, input logic signed [31:0] val);
        int gap;
        gap = send_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        operand_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic append_word(input logic signed [31:0] val);
        send_item(bse_pkg::OP_APPEND, val);
        if (loaded.size() < TABLE_DEPTH)
            loaded.push_back(val);
    endtask

    task automatic clear_words();
        send_item(bse_pkg::OP_CLEAR, rand_word());
        loaded.delete();
    endtask

    task automatic load_sorted(input int n, input bit dense);
        longint cur;
        longint step_max;
        clear_words();
        step_max = dense ? 64'd3 : 64'd4294967295 / (n + 1);
        if (dense)
            cur = longint'($urandom_range(0, 20)) - 10;
        else if ($urandom_range(0, 3) == 0)
            cur = WORD_MIN;
        else
            cur = WORD_MIN + longint'($urandom_range(0, 32'(step_max)));
        for (int i = 0; i < n; i++)
        begin
            append_word(cur[31:0]);
            cur += longint'($urandom_range(0, 32'(step_max)));
        end
    endtask

    task automatic test_directed_cases();
        send_item(bse_pkg::OP_SEARCH, '0);
        send_item(OP_UNUSED, W_MAX);
        append_word(W_MIN);
        append_word(-32'sd1);
        append_word('0);
        append_word(32'sd1);
        append_word(W_MAX);
        send_item(bse_pkg::OP_SEARCH, W_MIN);
        send_item(bse_pkg::OP_SEARCH, W_MAX);
        send_item(bse_pkg::OP_SEARCH, '0);
        send_item(bse_pkg::OP_SEARCH, -32'sd1);
        send_item(bse_pkg::OP_SEARCH, 32'sd1);
        send_item(bse_pkg::OP_SEARCH, 32'sd2);
        send_item(OP_UNUSED, W_MIN);
        send_item(bse_pkg::OP_SEARCH, W_MIN + 1);
        clear_words();
        send_item(bse_pkg::OP_SEARCH, '0);
        // duplicates
        append_word(32'sd5);
        append_word(32'sd5);
        append_word(32'sd5);
        send_item(bse_pkg::OP_SEARCH, 32'sd5);
        // unsorted table
        clear_words();
        append_word(32'sd9);
        append_word(32'sd1);
        append_word(32'sd7);
        append_word(32'sd3);
        send_item(bse_pkg::OP_SEARCH, 32'sd3);
        send_item(bse_pkg::OP_SEARCH, 32'sd9);
    endtask

    task automatic test_sorted_sets();
        int n;
        int searches;
        for (int s = 0; s < 8; s++)
        begin
            send_gaps = (s % 5 != 4);
            stall_pct = (s % 5 == 3) ? 0 : 25;
            n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 16) : $urandom_range(17, 64);
            load_sorted(n, $urandom_range(0, 3) == 0);
            searches = $urandom_range(4, 8);
            repeat (searches) send_item(bse_pkg::OP_SEARCH, pick_key());
        end
        send_gaps = 1'b1;
        stall_pct = 25;
    endtask

    task automatic test_full_table();
        send_gaps = 1'b0;
        stall_pct = 0;
        load_sorted(TABLE_DEPTH, 1'b0);
        send_gaps = 1'b1;
        stall_pct = 25;
        send_item(bse_pkg::OP_APPEND, W_MAX);
        send_item(bse_pkg::OP_APPEND, W_MIN);
        send_item(bse_pkg::OP_SEARCH, loaded[0]);
        send_item(bse_pkg::OP_SEARCH, loaded[TABLE_DEPTH - 1]);
        send_item(bse_pkg::OP_SEARCH, loaded[TABLE_DEPTH / 2]);
        send_item(bse_pkg::OP_SEARCH, W_MAX);
        repeat (8) send_item(bse_pkg::OP_SEARCH, pick_key());
    endtask

    task automatic test_backpressure();
        load_sorted(8, 1'b0);
        send_gaps = 1'b0;
        holds_asked++;
        repeat (16) send_item(bse_pkg::OP_SEARCH, pick_key());
        send_gaps = 1'b1;
    endtask

    task automatic test_random_mix();
        int r;
        clear_words();
        repeat (120)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                append_word(rand_word());
            else if (r < 75)
                send_item(bse_pkg::OP_SEARCH, pick_key());
            else if (r < 82)
                clear_words();
            else
                send_item(OP_UNUSED, rand_word());
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_sorted_sets();
        test_full_table();
        test_backpressure();
        test_random_mix();

        in_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d input transfers, %0d search results (%0d hits),", n_in, n_results,
                 n_hits);
        $display("%0d appends dropped on a full table, %0d mismatches over %0d cycles",
                 n_dropped, errors, cycle_count);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
